>>> hw/rtl/gdd_pkg.sv
package gdd_pkg;

    localparam int unsigned YearW  = 14;
    localparam int unsigned MonthW = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned DnW    = 23;
    localparam int unsigned CountW = 22;
    localparam int unsigned QuotW  = 8;
    localparam int unsigned OffW   = 9;

    localparam logic [YearW-1:0]  YearMax  = 14'd9999;
    localparam logic [MonthW-1:0] MonthFeb = 4'd2;
    localparam logic [MonthW-1:0] MonthDec = 4'd12;

    // Multiply by 5243 and shift right by 19 divides by 100 exactly for 14-bit values.
    localparam logic [12:0] Recip100 = 13'd5243;
    localparam int unsigned RecipShift = 19;
    localparam int unsigned ProdW = YearW + 13;

    typedef struct packed {
        logic [YearW-1:0]  year;
        logic [MonthW-1:0] month;
        logic [DayW-1:0]   day;
        logic [YearW-1:0]  prev_year;
        logic [QuotW-1:0]  prev_cent;
        logic [QuotW-1:0]  year_cent;
        logic [DnW-1:0]    year_days;
        logic              range_ok;
    } prep_t;

    typedef struct packed {
        logic [DnW-1:0] base;
        logic [OffW-1:0] offset;
        logic            ok;
    } part_t;

    function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
        logic [DayW-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2: len = 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [OffW-1:0] days_before(input logic [MonthW-1:0] m);
        logic [OffW-1:0] n;
        case (m)
            4'd2:  n = 9'd31;
            4'd3:  n = 9'd59;
            4'd4:  n = 9'd90;
            4'd5:  n = 9'd120;
            4'd6:  n = 9'd151;
            4'd7:  n = 9'd181;
            4'd8:  n = 9'd212;
            4'd9:  n = 9'd243;
            4'd10: n = 9'd273;
            4'd11: n = 9'd304;
            4'd12: n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

    function automatic prep_t date_prep(input logic [YearW-1:0] y,
                                        input logic [MonthW-1:0] m,
                                        input logic [DayW-1:0] d);
        prep_t r;
        logic [YearW-1:0] p;
        logic [ProdW-1:0] prod_p;
        logic [ProdW-1:0] prod_y;
        p = y - 14'd1;
        prod_p = ProdW'(p) * ProdW'(Recip100);
        prod_y = ProdW'(y) * ProdW'(Recip100);
        r.year = y;
        r.month = m;
        r.day = d;
        r.prev_year = p;
        r.prev_cent = prod_p[RecipShift +: QuotW];
        r.year_cent = prod_y[RecipShift +: QuotW];
        r.year_days = DnW'(p) * 23'd365;
        r.range_ok = (y != '0) && (y <= YearMax) && (m != '0) && (m <= MonthDec)
                     && (d != '0);
        return r;
    endfunction

    function automatic part_t date_part(input prep_t a);
        part_t r;
        logic [YearW:0] cent_mul;
        logic [YearW-1:0] rem;
        logic leap;
        logic [DayW:0] len;
        cent_mul = (YearW+1)'(a.year_cent) * 15'd100;
        rem = a.year - cent_mul[YearW-1:0];
        leap = (rem != '0) ? (a.year[1:0] == 2'b00) : (a.year_cent[1:0] == 2'b00);
        len = {1'b0, month_len(a.month)} + {5'd0, (a.month == MonthFeb) && leap};
        r.base = a.year_days + DnW'(a.prev_year[YearW-1:2]) - DnW'(a.prev_cent)
                 + DnW'(a.prev_cent[QuotW-1:2]);
        r.offset = days_before(a.month) + OffW'((a.month > MonthFeb) && leap)
                   + OffW'(a.day);
        r.ok = a.range_ok && ({1'b0, a.day} <= len);
        return r;
    endfunction

endpackage

>>> hw/rtl/gregorian_date_difference_top.sv
// Each accepted word passes the prep, part, day number and count registers.
// Throughput: one word per cycle unless m_tready stalls the output; stages
// advance independently, so a bubble is squeezed out while the output waits.
// Reset: synchronous, active low; it clears the stage valid bits only, and the
// payload registers are left as they are.
module gregorian_date_difference_top import gdd_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day,
    // count_end_day, zero pad
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // day_count, zero pad
    output logic [23:0] m_tdata,
    // date_error
    output logic        m_tuser
);

    logic v1_reg, v2_reg, v3_reg, vo_reg;
    logic en1, en2, en3, en_o;

    prep_t prep_a_reg, prep_b_reg, prep_a_next, prep_b_next;
    logic  inc1_reg;
    part_t part_a_reg, part_b_reg, part_a_next, part_b_next;
    logic  inc2_reg;
    logic [DnW-1:0] dn_a_reg, dn_b_reg, dn_a_next, dn_b_next;
    logic  inc3_reg, err3_reg, err3_next;
    logic [CountW-1:0] count_reg, count_next;
    logic  err_o_reg;
    logic [DnW-1:0] diff;

    assign en_o = !vo_reg || m_tready;
    assign en3  = !v3_reg || en_o;
    assign en2  = !v2_reg || en3;
    assign en1  = !v1_reg || en2;
    assign s_tready = en1;

    always_comb begin
        prep_a_next = date_prep(s_tdata[13:0], s_tdata[17:14], s_tdata[22:18]);
        prep_b_next = date_prep(s_tdata[36:23], s_tdata[40:37], s_tdata[45:41]);
        part_a_next = date_part(prep_a_reg);
        part_b_next = date_part(prep_b_reg);
        dn_a_next = part_a_reg.base + DnW'(part_a_reg.offset);
        dn_b_next = part_b_reg.base + DnW'(part_b_reg.offset);
        err3_next = !(part_a_reg.ok && part_b_reg.ok);
        diff = (dn_a_reg < dn_b_reg) ? (dn_b_reg - dn_a_reg) : '0;
        count_next = err3_reg ? '0 : (diff[CountW-1:0] + CountW'(inc3_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en_o) vo_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            prep_a_reg <= prep_a_next;
            prep_b_reg <= prep_b_next;
            inc1_reg <= s_tdata[46];
        end
        if (en2) begin
            part_a_reg <= part_a_next;
            part_b_reg <= part_b_next;
            inc2_reg <= inc1_reg;
        end
        if (en3) begin
            dn_a_reg <= dn_a_next;
            dn_b_reg <= dn_b_next;
            err3_reg <= err3_next;
            inc3_reg <= inc2_reg;
        end
        if (en_o) begin
            count_reg <= count_next;
            err_o_reg <= err3_reg;
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {2'b00, count_reg};
    assign m_tuser  = err_o_reg;

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[CountW-1:0] == '0)
        else $error("error result carries a nonzero count");

    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[CountW-1:0] <= 22'd3652059)
        else $error("day count above the largest possible span");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> v1_reg)
        else $error("accepted word missing from the first stage");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        v3_reg && en_o |=> m_tvalid)
        else $error("last stage word lost on its way to the output");

endmodule

>>> tb/tb_gregorian_date_difference_top.sv
module tb_gregorian_date_difference_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gdd_pkg::*;

    typedef struct {
        logic [CountW-1:0] day_count;
        logic              date_error;
    } span_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    logic [47:0] pending_words[$];
    span_t       expected_spans[$];
    logic        in_taken = 1'b0;

    int unsigned tx_idle_pct = 0;
    int unsigned rx_stall_pct = 0;
    int unsigned rx_hold_left = 0;
    int unsigned queued_cnt = 0;
    int unsigned accepted_cnt = 0;
    int unsigned results_cnt = 0;
    int unsigned mismatch_cnt = 0;

    gregorian_date_difference_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 aclk = ~aclk;

    function automatic int unsigned month_days(int unsigned y, int unsigned m);
        bit leap;
        leap = (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        case (m)
            2: return leap ? 29 : 28;
            4, 6, 9, 11: return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default: return 0;
        endcase
    endfunction

    function automatic bit date_ok(int unsigned y, int unsigned m, int unsigned d);
        return (y >= 1) && (y <= YearMax) && (d >= 1) && (d <= month_days(y, m));
    endfunction

    function automatic int unsigned serial_day(int unsigned y, int unsigned m,
                                               int unsigned d);
        int unsigned p;
        int unsigned n;
        p = y - 1;
        n = 365 * p + p / 4 - p / 100 + p / 400 + d;
        for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
        return n;
    endfunction

    function automatic span_t predict_span(logic [47:0] w);
        span_t       r;
        int unsigned sy, sm, sd, ey, em, ed;
        int unsigned a, b;
        sy = w[13:0];
        sm = w[17:14];
        sd = w[22:18];
        ey = w[36:23];
        em = w[40:37];
        ed = w[45:41];
        r.day_count = '0;
        r.date_error = 1'b0;
        if (!date_ok(sy, sm, sd) || !date_ok(ey, em, ed)) begin
            r.date_error = 1'b1;
        end else begin
            a = serial_day(sy, sm, sd);
            b = serial_day(ey, em, ed);
            r.day_count = CountW'(((a < b) ? (b - a) : 0) + w[46]);
        end
        return r;
    endfunction

    task automatic queue_pair(int unsigned sy, int unsigned sm, int unsigned sd,
                              int unsigned ey, int unsigned em, int unsigned ed,
                              int unsigned inc);
        pending_words.push_back({1'b0, 1'(inc), DayW'(ed), MonthW'(em), YearW'(ey),
                                 DayW'(sd), MonthW'(sm), YearW'(sy)});
        queued_cnt++;
    endtask

    task automatic pick_date(output int unsigned y, output int unsigned m,
                             output int unsigned d);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 8) begin
            y = $urandom_range(16383);
            m = $urandom_range(15);
            d = $urandom_range(31);
        end else begin
            if (pick < 30) begin
                case ($urandom_range(9))
                    0: y = 1;
                    1: y = 4;
                    2: y = 100;
                    3: y = 400;
                    4: y = 1600;
                    5: y = 1900;
                    6: y = 2000;
                    7: y = 2100;
                    8: y = 2400;
                    default: y = 9999;
                endcase
            end else begin
                y = $urandom_range(9999, 1);
            end
            m = $urandom_range(12, 1);
            if (pick < 12) begin
                d = month_days(y, m) + 1;
            end else if (pick < 16) begin
                m = 2;
                d = 29;
            end else begin
                d = $urandom_range(month_days(y, m), 1);
            end
        end
    endtask

    task automatic queue_random(int unsigned n);
        int unsigned sy, sm, sd, ey, em, ed, t;
        repeat (n) begin
            pick_date(sy, sm, sd);
            pick_date(ey, em, ed);
            if ($urandom_range(99) < 25) begin
                ey = sy;
                em = $urandom_range(12, 1);
                ed = $urandom_range(month_days(ey, em), 1);
            end
            // Most pairs run forward in time so that the count is not zero.
            if (date_ok(sy, sm, sd) && date_ok(ey, em, ed)
                    && serial_day(sy, sm, sd) > serial_day(ey, em, ed)
                    && $urandom_range(99) < 70) begin
                t = sy; sy = ey; ey = t;
                t = sm; sm = em; em = t;
                t = sd; sd = ed; ed = t;
            end
            queue_pair(sy, sm, sd, ey, em, ed, $urandom_range(1));
        end
    endtask

    task automatic drain();
        do begin
            @(negedge aclk);
        end while (accepted_cnt != queued_cnt || expected_spans.size() != 0);
    endtask

    task automatic set_phase(int unsigned tx_pct, int unsigned rx_pct);
        @(posedge aclk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_words.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(negedge aclk) begin
        if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    always @(posedge aclk) begin
        span_t want;
        in_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_spans.push_back(predict_span(s_tdata));
                accepted_cnt++;
            end
            if (m_tvalid && m_tready) begin
                results_cnt++;
                if (expected_spans.size() == 0) begin
                    $display("%0t: unexpected result word: day_count %0d, date_error %0b",
                             $time, m_tdata[CountW-1:0], m_tuser);
                    mismatch_cnt++;
                end else begin
                    want = expected_spans.pop_front();
                    if (m_tdata !== {{(24 - CountW){1'b0}}, want.day_count}) begin
                        $display("%0t: day_count mismatch: expected %0d, actual %0d (tdata 0x%06h)",
                                 $time, want.day_count, m_tdata[CountW-1:0], m_tdata);
                        mismatch_cnt++;
                    end
                    if (m_tuser !== want.date_error) begin
                        $display("%0t: date_error mismatch: expected %0b, actual %0b",
                                 $time, want.date_error, m_tuser);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        set_phase(0, 0);
        queue_pair(1, 1, 1, 9999, 12, 31, 1);
        queue_pair(1, 1, 1, 9999, 12, 31, 0);
        queue_pair(9999, 12, 31, 1, 1, 1, 0);
        queue_pair(9999, 12, 31, 1, 1, 1, 1);
        queue_pair(2024, 3, 15, 2024, 3, 15, 0);
        queue_pair(2024, 3, 15, 2024, 3, 15, 1);
        queue_pair(2000, 2, 28, 2000, 2, 29, 0);
        queue_pair(1900, 2, 29, 1901, 1, 1, 1);
        queue_pair(2020, 1, 1, 2023, 2, 29, 0);
        queue_pair(2024, 2, 29, 2025, 3, 1, 0);
        queue_pair(1600, 2, 29, 1700, 3, 1, 1);
        queue_pair(0, 1, 1, 1, 1, 1, 0);
        queue_pair(1, 1, 1, 10000, 1, 1, 1);
        queue_pair(16383, 15, 31, 16383, 15, 31, 1);
        queue_pair(2010, 0, 10, 2011, 5, 10, 0);
        queue_pair(2010, 13, 10, 2011, 5, 10, 0);
        queue_pair(2010, 5, 0, 2011, 5, 10, 1);
        queue_pair(2021, 4, 31, 2022, 1, 1, 0);
        queue_pair(1999, 12, 31, 2000, 1, 1, 0);
        queue_pair(2100, 2, 28, 2100, 3, 1, 0);
        queue_pair(1, 1, 1, 1, 1, 2, 0);
        queue_pair(0, 0, 0, 0, 0, 0, 0);
        drain();

        // The receiver holds off while the sender keeps offering words.
        @(posedge aclk);
        rx_hold_left = 300;
        queue_random(460);
        drain();

        set_phase(85, 0);
        queue_random(460);
        drain();

        set_phase(0, 85);
        queue_random(460);
        drain();

        set_phase(25, 25);
        queue_random(470);
        drain();

        repeat (16) @(posedge aclk);
        $display("Checked %0d result words against %0d accepted date pairs in four flow phases.",
                 results_cnt, accepted_cnt);
        $display("Stimulus spanned leap-year edges, equal and reversed dates, and bad fields.");
        if (mismatch_cnt == 0) begin
            $display("gregorian_date_difference_top verification clean");
        end else begin
            $display("gregorian_date_difference_top verification failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Timeout with %0d results still expected.", expected_spans.size());
        $display("gregorian_date_difference_top verification failed");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/gdd_pkg.sv
hw/rtl/gregorian_date_difference_top.sv
tb/tb_gregorian_date_difference_top.sv
